### rtl/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for the integer to ASCII converter
// Holds field widths, character codes, the command codes, the controller
// states, the digit cell control group and the digit to character mapping.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // Default sizes for the top level parameters
    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 32;

    // Fixed field widths
    localparam int VALUE_W = 32;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 6;

    // Command codes
    localparam logic CMD_SIGNED_DEC     = 1'b0;
    localparam logic CMD_UNSIGNED_RADIX = 1'b1;

    // Radix limits and the decimal base
    localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
    localparam logic [RADIX_W-1:0] DECIMAL_BASE = 6'd10;
    localparam logic [DIGIT_W-1:0] DEC_DIGIT_MAX = 6'd9;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    // Control group broadcast to every digit cell
    typedef struct packed {
        logic               clear;
        logic               shift;
        logic [RADIX_W-1:0] radix;
    } t_cell_ctrl;

    // Map a digit value to its ASCII character, letters above nine
    function automatic logic [CHAR_W-1:0] f_digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] v;
        v = CHAR_W'(d);
        if (d > DEC_DIGIT_MAX) begin
            return v + CHAR_UPPER_A - CHAR_W'(DECIMAL_BASE);
        end
        return v + CHAR_ZERO;
    endfunction

endpackage

### rtl/itoa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_in_if: request channel of the integer to ASCII converter
// Carries the command, the radix and the value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface itoa_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [itoa_pkg::RADIX_W-1:0] radix;
    logic [itoa_pkg::VALUE_W-1:0] value;

    modport source(output valid, output command, output radix, output value, input ready);
    modport sink(input valid, input command, input radix, input value, output ready);
endinterface

### rtl/itoa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_out_if: character channel of the integer to ASCII converter
// Carries one ASCII character and its last flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface itoa_out_if;
    logic                        valid;
    logic                        ready;
    logic [itoa_pkg::CHAR_W-1:0] char_code;
    logic                        last;

    modport source(output valid, output char_code, output last, input ready);
    modport sink(input valid, input char_code, input last, output ready);
endinterface

### rtl/itoa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_cell: one digit cell of the systolic radix converter
// Doubles its digit and adds the incoming carry, reduces modulo the radix and
// passes the carry and the step enable one cell up through registers. In the
// output phase the row acts as a shift register toward the top cell.
// ----------------------------------------------------------------------------
module itoa_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  itoa_pkg::t_cell_ctrl         i_ctrl,
    input  logic                         i_en,
    input  logic                         i_carry,
    input  logic [itoa_pkg::DIGIT_W-1:0] i_lower,
    output logic                         o_en,
    output logic                         o_carry,
    output logic [itoa_pkg::DIGIT_W-1:0] o_digit
);

    logic [itoa_pkg::DIGIT_W-1:0] r_digit;
    logic [itoa_pkg::DIGIT_W-1:0] n_digit;
    logic                         r_en;
    logic                         r_carry;
    logic [itoa_pkg::DIGIT_W:0]   w_sum;
    logic [itoa_pkg::DIGIT_W:0]   w_rad;
    logic                         w_ge;

    // Double and add carry, subtract the radix once on overflow
    always_comb begin
        w_sum = {r_digit, i_carry};
        w_rad = {1'b0, i_ctrl.radix};
        w_ge  = (w_sum >= w_rad);
        if (w_ge) begin
            n_digit = itoa_pkg::DIGIT_W'(w_sum - w_rad);
        end else begin
            n_digit = itoa_pkg::DIGIT_W'(w_sum);
        end
    end

    // Digit: clear on a new transaction, shift in output phase, step when enabled
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_digit <= '0;
        end else if (i_ctrl.shift) begin
            r_digit <= i_lower;
        end else if (i_en) begin
            r_digit <= n_digit;
        end
    end

    // Pass enable and carry to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_en    <= 1'b0;
            r_carry <= 1'b0;
        end else begin
            r_en    <= i_en;
            r_carry <= i_en & w_ge;
        end
    end

    assign o_en    = r_en;
    assign o_carry = r_carry;
    assign o_digit = r_digit;

endmodule

### rtl/integer_to_ascii_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: integer to ASCII text converter
// Converts one value per transaction to signed decimal or unsigned radix text,
// most significant character first, with last on the final character.
// ----------------------------------------------------------------------------
// One request is handled at a time. After acceptance the value is shifted
// MSB first into a skewed row of MAX_DIGITS digit cells, one bit per cycle,
// and the carries ripple up through a register per cell. Leading zeros are
// then shifted out of the top cell at one per cycle. The characters, after a
// minus sign when one is sent, then go out at one per cycle while the sink
// is ready, and output stalls keep the block busy; the input is ready again
// the cycle after the last character is taken. Text longer than MAX_DIGITS
// characters keeps only its least significant ones.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = itoa_pkg::MAX_DIGITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    itoa_in_if.sink       i_in,
    itoa_out_if.source    o_out
);

    localparam int CW = $clog2(VALUE_BITS + MAX_DIGITS + 1);
    localparam int LW = $clog2(MAX_DIGITS + 1);
    localparam logic [CW-1:0] FEED_END  = CW'(VALUE_BITS);
    localparam logic [CW-1:0] CONV_LAST = CW'(VALUE_BITS + MAX_DIGITS - 1);
    localparam logic [LW-1:0] LEFT_FULL = LW'(MAX_DIGITS);
    localparam logic [LW-1:0] LEFT_ONE  = LW'(1);

    itoa_pkg::t_state             r_state, n_state;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic [LW-1:0]                r_left, n_left;
    logic [VALUE_BITS-1:0]        r_bits, n_bits;
    logic                         r_neg, n_neg;
    logic [itoa_pkg::RADIX_W-1:0] r_radix, n_radix;
    logic                         r_ovf, n_ovf;

    logic                         w_in_acc;
    logic                         w_out_acc;
    logic [VALUE_BITS-1:0]        w_val;
    logic                         w_is_neg;
    logic [itoa_pkg::RADIX_W-1:0] w_radix_sel;
    logic                         w_feed;
    logic                         w_skip;
    itoa_pkg::t_cell_ctrl         w_ctrl;

    logic [MAX_DIGITS:0]          w_en;
    logic [MAX_DIGITS:0]          w_carry;
    logic [itoa_pkg::DIGIT_W-1:0] w_digit [MAX_DIGITS];
    logic [itoa_pkg::DIGIT_W-1:0] w_lower [MAX_DIGITS];
    logic [itoa_pkg::DIGIT_W-1:0] w_top;

    assign w_in_acc  = i_in.valid & i_in.ready;
    assign w_out_acc = o_out.valid & o_out.ready;
    assign w_val     = VALUE_BITS'(i_in.value);
    assign w_is_neg  = (i_in.command == itoa_pkg::CMD_SIGNED_DEC) & w_val[VALUE_BITS-1];
    assign w_top     = w_digit[MAX_DIGITS-1];
    assign w_skip    = !r_ovf && (w_top == '0) && (r_left > LEFT_ONE);

    // Select the radix: decimal for signed, clamped radix otherwise
    always_comb begin
        if (i_in.command == itoa_pkg::CMD_SIGNED_DEC) begin
            w_radix_sel = itoa_pkg::DECIMAL_BASE;
        end else if (i_in.radix < itoa_pkg::RADIX_MIN) begin
            w_radix_sel = itoa_pkg::RADIX_MIN;
        end else if (i_in.radix > itoa_pkg::RADIX_MAX) begin
            w_radix_sel = itoa_pkg::RADIX_MAX;
        end else begin
            w_radix_sel = i_in.radix;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            itoa_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = itoa_pkg::S_CONV;
                end
            end
            itoa_pkg::S_CONV: begin
                if (r_cnt == CONV_LAST) begin
                    n_state = itoa_pkg::S_SKIP;
                end
            end
            itoa_pkg::S_SKIP: begin
                if (!w_skip) begin
                    if (r_neg && (r_left != LEFT_FULL)) begin
                        n_state = itoa_pkg::S_SIGN;
                    end else begin
                        n_state = itoa_pkg::S_EMIT;
                    end
                end
            end
            itoa_pkg::S_SIGN: begin
                if (w_out_acc) begin
                    n_state = itoa_pkg::S_EMIT;
                end
            end
            itoa_pkg::S_EMIT: begin
                if (w_out_acc && (r_left == LEFT_ONE)) begin
                    n_state = itoa_pkg::S_IDLE;
                end
            end
            default: n_state = itoa_pkg::S_IDLE;
        endcase
    end

    // Outputs and cell control
    always_comb begin
        i_in.ready      = 1'b0;
        o_out.valid     = 1'b0;
        o_out.char_code = itoa_pkg::f_digit_char(w_top);
        o_out.last      = 1'b0;
        w_feed          = 1'b0;
        w_ctrl.clear    = 1'b0;
        w_ctrl.shift    = 1'b0;
        w_ctrl.radix    = r_radix;
        case (r_state)
            itoa_pkg::S_IDLE: begin
                i_in.ready   = 1'b1;
                w_ctrl.clear = i_in.valid;
            end
            itoa_pkg::S_CONV: begin
                w_feed = (r_cnt < FEED_END);
            end
            itoa_pkg::S_SKIP: begin
                w_ctrl.shift = w_skip;
            end
            itoa_pkg::S_SIGN: begin
                o_out.valid     = 1'b1;
                o_out.char_code = itoa_pkg::CHAR_MINUS;
            end
            itoa_pkg::S_EMIT: begin
                o_out.valid  = 1'b1;
                o_out.last   = (r_left == LEFT_ONE);
                w_ctrl.shift = w_out_acc && (r_left != LEFT_ONE);
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_bits  = r_bits;
        n_neg   = r_neg;
        n_radix = r_radix;
        n_ovf   = r_ovf;
        case (r_state)
            itoa_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_bits  = w_is_neg ? (~w_val + 1'b1) : w_val;
                    n_neg   = w_is_neg;
                    n_radix = w_radix_sel;
                    n_cnt   = '0;
                    n_left  = LEFT_FULL;
                    n_ovf   = 1'b0;
                end
            end
            itoa_pkg::S_CONV: begin
                n_cnt  = r_cnt + 1'b1;
                n_bits = {r_bits[VALUE_BITS-2:0], 1'b0};
                n_ovf  = r_ovf | w_carry[MAX_DIGITS];
            end
            itoa_pkg::S_SKIP: begin
                if (w_skip) begin
                    n_left = r_left - 1'b1;
                end
            end
            itoa_pkg::S_EMIT: begin
                if (w_out_acc) begin
                    n_left = r_left - 1'b1;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::S_IDLE;
            r_cnt   <= '0;
            r_left  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_ovf   <= n_ovf;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_bits  <= n_bits;
        r_neg   <= n_neg;
        r_radix <= n_radix;
    end

    // Feed the value MSB first into the bottom cell
    assign w_en[0]    = w_feed;
    assign w_carry[0] = w_feed & r_bits[VALUE_BITS-1];

    // Row of digit cells, least significant at the bottom
    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        if (g == 0) begin : g_bottom
            assign w_lower[g] = '0;
        end else begin : g_upper
            assign w_lower[g] = w_digit[g-1];
        end

        itoa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_en    (w_en[g]),
            .i_carry (w_carry[g]),
            .i_lower (w_lower[g]),
            .o_en    (w_en[g+1]),
            .o_carry (w_carry[g+1]),
            .o_digit (w_digit[g])
        );
    end

`ifndef ASSERT_OFF
    // Never take a request while a character is on offer
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while output valid");

    // A shown digit is always below the radix
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itoa_pkg::S_EMIT) |-> (w_top < r_radix))
        else $error("digit not below radix");

    // Character count never runs out while output is valid
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_left != '0))
        else $error("character count empty while valid");

    // After the last character the block is ready for a new request
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.last) |=> i_in.ready)
        else $error("not ready after last character");
`endif

endmodule
